// ===== hw/rtl/gphc_pkg.sv =====
// Shared types, codes and constants of the gamepad hold counter.
// Used by gphc_ctrl, gphc_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gphc_pkg;

  localparam int NBTN = 16;
  localparam int NRAW = 12;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 40;

  // action codes carried on s_tuser
  localparam logic [2:0] ACT_KEY   = 3'd0;
  localparam logic [2:0] ACT_FRAME = 3'd1;
  localparam logic [2:0] ACT_SET   = 3'd2;
  localparam logic [2:0] ACT_SWAP  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // direction buttons 12..15, selected by the two low bits of the index
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic signed [10:0] AXIS_POS_FORCE  = 11'sd1000;
  localparam logic signed [10:0] AXIS_NEG_FORCE  = -11'sd1000;
  localparam logic signed [10:0] AXIS_POS_THRESH = 11'sd100;
  localparam logic signed [10:0] AXIS_NEG_THRESH = -11'sd100;

  // input beat fields, last field in the lowest bits
  typedef struct packed {
    logic [3:0]  new_button;
    logic [10:0] axis_y;
    logic [10:0] axis_x;
    logic [11:0] raw_buttons;
    logic        key_down;
    logic [7:0]  key_code;
    logic [1:0]  slot;
    logic [3:0]  button;
    logic [1:0]  pad;
  } in_item_t;

  typedef struct packed {
    logic sweep_wr;  // write reset contents at the sweep position
    logic in_load;   // capture an input beat
    logic key_wr;    // update the pressed-key map
    logic slot_wr;   // write one key slot
    logic idx_clr;   // clear button and slot indexes
    logic hit_clr;   // clear the key hit vector
    logic scan_rd;   // read one key slot and advance the scan
    logic bm_rd_b;   // read the button map at the item's button
    logic bm_rd_j;   // read the button map at the running index
    logic save_old;  // hold the button map entry just read
    logic bm_wr_j;   // write the held entry at the matched index
    logic bm_wr_b;   // write the new raw button at the item's button
    logic btn_rd;    // read counter and map for the running index
    logic btn_upd;   // update the counter and load the output
    logic rd_out;    // load the button map read result
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       pad_ok;
    logic       slot_ok;
    logic       b_lt12;
    logic       nb_lt12;
    logic       match;
    logic       jq_last;
    logic       sweep_last;
    logic       scan_last;
    logic       idx_last;
    logic       out_free;
  } dp_status_t;

  // factory key codes of pad 0
  function automatic logic [7:0] default_key(input logic [3:0] b, input logic [2:0] s);
    logic [7:0] code;
    code = 8'h00;
    case ({b, s})
      {4'd0, 3'd0}:  code = 8'h2C;
      {4'd0, 3'd1}:  code = 8'h1C;
      {4'd0, 3'd2}:  code = 8'h39;
      {4'd1, 3'd0}:  code = 8'h2D;
      {4'd1, 3'd1}:  code = 8'h0E;
      {4'd2, 3'd0}:  code = 8'h2E;
      {4'd3, 3'd0}:  code = 8'h2F;
      {4'd9, 3'd0}:  code = 8'h1E;
      {4'd10, 3'd0}: code = 8'h1F;
      {4'd11, 3'd0}: code = 8'h01;
      {4'd12, 3'd0}: code = 8'hCB;
      {4'd13, 3'd0}: code = 8'hCD;
      {4'd14, 3'd0}: code = 8'hC8;
      {4'd15, 3'd0}: code = 8'hD0;
      default:       code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gphc_ctrl.sv =====
// Sequencer of the gamepad hold counter: one state machine that steps the
// datapath through each action. Depends on gphc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gphc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gphc_pkg::dp_status_t  status,
  output gphc_pkg::dp_cmd_t     cmd
);
  import gphc_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_RD_OUT, ST_SW_B, ST_SW_SCAN, ST_SW_WB,
    ST_SCAN, ST_DRAIN1, ST_DRAIN2, ST_BTN_RD, ST_BTN_UP
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (status.action)
          ACT_KEY: cmd.key_wr = 1'b1;
          ACT_SET: cmd.slot_wr = status.pad_ok && status.slot_ok;
          ACT_SWAP: begin
            if (status.pad_ok && status.b_lt12 && status.nb_lt12) begin
              cmd.bm_rd_b = 1'b1;
              cmd.idx_clr = 1'b1;
              state_next = ST_SW_B;
            end
          end
          ACT_READ: begin
            if (status.pad_ok) begin
              cmd.bm_rd_b = 1'b1;
              state_next = ST_RD_OUT;
            end
          end
          ACT_FRAME: begin
            if (status.pad_ok) begin
              cmd.idx_clr = 1'b1;
              cmd.hit_clr = 1'b1;
              state_next = ST_SCAN;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RD_OUT: begin
        if (status.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SW_B: begin
        cmd.save_old = 1'b1;
        cmd.bm_rd_j = 1'b1;
        state_next = ST_SW_SCAN;
      end
      ST_SW_SCAN: begin
        if (status.match) begin
          cmd.bm_wr_j = 1'b1;
          state_next = ST_SW_WB;
        end else if (status.jq_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.bm_rd_j = 1'b1;
        end
      end
      ST_SW_WB: begin
        cmd.bm_wr_b = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) state_next = ST_DRAIN1;
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_BTN_RD;
      ST_BTN_RD: begin
        cmd.btn_rd = 1'b1;
        state_next = ST_BTN_UP;
      end
      ST_BTN_UP: begin
        if (status.out_free) begin
          cmd.btn_upd = 1'b1;
          state_next = status.idx_last ? ST_IDLE : ST_BTN_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gphc_dp.sv =====
// Datapath of the gamepad hold counter: key, key-map, button-map and counter
// stores, the key scan pipeline, the counter update and the output register.
// Depends on gphc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gphc_dp #(
  parameter int PADS            = 4,
  parameter int KEYS_PER_BUTTON = 4,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gphc_pkg::dp_cmd_t                 cmd,
  output gphc_pkg::dp_status_t              status,
  input  gphc_pkg::in_item_t                item,
  input  logic [2:0]                        action,
  input  logic                              cfg_valid,
  input  logic                              cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [gphc_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                              out_last
);
  import gphc_pkg::*;

  localparam int ROWS     = PADS * NBTN;
  localparam int KM_DEPTH = ROWS * KEYS_PER_BUTTON;
  localparam int BM_DEPTH = PADS * NRAW;
  localparam int HC_AW    = $clog2(ROWS);
  localparam int KM_AW    = $clog2(KM_DEPTH);
  localparam int BM_AW    = $clog2(BM_DEPTH);
  localparam int S_W      = (KEYS_PER_BUTTON > 1) ? $clog2(KEYS_PER_BUTTON) : 1;
  localparam logic [S_W-1:0]   S_LAST   = S_W'(KEYS_PER_BUTTON - 1);
  localparam logic [HC_AW-1:0] ROW_LAST = HC_AW'(ROWS - 1);
  localparam logic [3:0]       RAW_LAST = 4'(NRAW - 1);
  localparam logic [3:0]       BTN_LAST = 4'(NBTN - 1);
  localparam logic [3:0]       NRAW4    = 4'(NRAW);

  logic             enable_key_override;
  in_item_t         item_q;
  logic [2:0]       action_q;
  logic [HC_AW-1:0] sw_row;
  logic [S_W-1:0]   sw_s;
  logic [3:0]       idx_b;
  logic [S_W-1:0]   scan_s;
  logic [3:0]       rd_idx;
  logic [3:0]       old_b;
  logic [NBTN-1:0]  key_hit;
  logic [255:0]     key_pressed;

  logic [7:0]             km_mem [KM_DEPTH];
  logic [3:0]             bm_mem [BM_DEPTH];
  logic [COUNT_WIDTH-1:0] hc_mem [ROWS];

  logic [7:0]             km_q;
  logic [3:0]             bm_q;
  logic [COUNT_WIDTH-1:0] hc_q;

  logic       v1, v2, nz2, kp_q;
  logic [3:0] tag1, tag2;

  logic [3:0]  out_index;
  logic [31:0] out_count;
  logic [3:0]  out_mapped;

  logic [5:0]             row_in, row_btn;
  logic                   sw_pad0, sw_bm_en;
  logic [3:0]             j_rd, j_cl, bm_raw;
  logic signed [10:0]     ax_eff, ay_eff;
  logic                   held;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [31:0]            cnt_rep;

  assign row_in   = {item_q.pad, idx_b};
  assign row_btn  = {item_q.pad, item_q.button};
  assign sw_pad0  = ((sw_row >> 4) == '0);
  assign sw_bm_en = (sw_s == '0) && (sw_row[3:0] < NRAW4);

  // configuration and input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_key_override <= 1'b1;
    end else if (cfg_valid) begin
      enable_key_override <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      item_q   <= item;
      action_q <= action;
    end
    if (cmd.save_old) old_b <= bm_q;
  end

  // sweep, scan and button indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_row <= '0;
      sw_s   <= '0;
      idx_b  <= '0;
      scan_s <= '0;
      rd_idx <= '0;
    end else begin
      if (cmd.sweep_wr) begin
        if (sw_s == S_LAST) begin
          sw_s   <= '0;
          sw_row <= sw_row + 1'b1;
        end else begin
          sw_s <= sw_s + 1'b1;
        end
      end
      if (cmd.idx_clr) begin
        idx_b  <= '0;
        scan_s <= '0;
      end else if (cmd.scan_rd) begin
        if (scan_s == S_LAST) begin
          scan_s <= '0;
          idx_b  <= idx_b + 1'b1;
        end else begin
          scan_s <= scan_s + 1'b1;
        end
      end else if (cmd.bm_rd_j || cmd.btn_upd) begin
        idx_b <= idx_b + 1'b1;
      end
      if (cmd.bm_rd_j) rd_idx <= idx_b;
    end
  end

  // pressed-key map
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pressed <= '0;
    end else if (cmd.key_wr) begin
      key_pressed[item_q.key_code] <= item_q.key_down;
    end
  end

  // key map store
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      km_mem[KM_AW'(sw_row * KEYS_PER_BUTTON + sw_s)] <=
          sw_pad0 ? default_key(sw_row[3:0], 3'(sw_s)) : 8'h00;
    end else if (cmd.slot_wr) begin
      km_mem[KM_AW'(row_btn * KEYS_PER_BUTTON + item_q.slot)] <= item_q.key_code;
    end
    if (cmd.scan_rd) km_q <= km_mem[KM_AW'(row_in * KEYS_PER_BUTTON + scan_s)];
  end

  // key scan: slot read, key lookup, hit merge
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
    end
    tag1 <= idx_b;
    tag2 <= tag1;
    nz2  <= (km_q != 8'h00);
    kp_q <= key_pressed[km_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_clr) begin
      key_hit <= '0;
    end else if (v2 && nz2 && kp_q) begin
      key_hit[tag2] <= 1'b1;
    end
  end

  // button map store
  assign j_rd = cmd.bm_rd_b ? item_q.button : idx_b;
  assign j_cl = (j_rd < NRAW4) ? j_rd : 4'd0;

  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      if (sw_bm_en) bm_mem[BM_AW'((sw_row >> 4) * NRAW + sw_row[3:0])] <= sw_row[3:0];
    end else if (cmd.bm_wr_j) begin
      bm_mem[BM_AW'(item_q.pad * NRAW + rd_idx)] <= old_b;
    end else if (cmd.bm_wr_b) begin
      bm_mem[BM_AW'(item_q.pad * NRAW + item_q.button)] <= item_q.new_button;
    end
    if (cmd.bm_rd_b || cmd.bm_rd_j || cmd.btn_rd) begin
      bm_q <= bm_mem[BM_AW'(item_q.pad * NRAW + j_cl)];
    end
  end

  // hold counter store
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      if (sw_s == '0) hc_mem[sw_row] <= '0;
    end else if (cmd.btn_upd) begin
      hc_mem[HC_AW'(row_in)] <= cnt_new;
    end
    if (cmd.btn_rd) hc_q <= hc_mem[HC_AW'(row_in)];
  end

  // held decision and counter update
  assign bm_raw = (bm_q >= NRAW4) ? 4'(bm_q - NRAW4) : bm_q;

  always_comb begin
    ax_eff = $signed(item_q.axis_x);
    ay_eff = $signed(item_q.axis_y);
    if (enable_key_override) begin
      if (key_hit[12] && !key_hit[13]) ax_eff = AXIS_NEG_FORCE;
      else if (!key_hit[12] && key_hit[13]) ax_eff = AXIS_POS_FORCE;
      if (key_hit[14] && !key_hit[15]) ay_eff = AXIS_NEG_FORCE;
      else if (!key_hit[14] && key_hit[15]) ay_eff = AXIS_POS_FORCE;
    end
  end

  always_comb begin
    held = 1'b0;
    if (idx_b < NRAW4) begin
      held = item_q.raw_buttons[bm_raw] || (enable_key_override && key_hit[idx_b]);
    end else begin
      case (idx_b[1:0])
        DIR_LEFT:  held = (ax_eff <= AXIS_NEG_THRESH);
        DIR_RIGHT: held = (ax_eff >= AXIS_POS_THRESH);
        DIR_UP:    held = (ay_eff <= AXIS_NEG_THRESH);
        DIR_DOWN:  held = (ay_eff >= AXIS_POS_THRESH);
        default:   held = 1'b0;
      endcase
    end
  end

  assign cnt_new = !held ? '0 : ((&hc_q) ? hc_q : hc_q + 1'b1);

  generate
    if (COUNT_WIDTH > 32) begin : g_sat
      assign cnt_rep = (|cnt_new[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cnt_new[31:0];
    end else begin : g_ext
      assign cnt_rep = 32'(cnt_new);
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.btn_upd || cmd.rd_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.btn_upd) begin
      out_index  <= idx_b;
      out_count  <= cnt_rep;
      out_mapped <= 4'd0;
      out_last   <= (idx_b == BTN_LAST);
    end else if (cmd.rd_out) begin
      out_index  <= item_q.button;
      out_count  <= 32'd0;
      out_mapped <= (item_q.button < NRAW4) ? bm_q : 4'd0;
      out_last   <= 1'b1;
    end
  end

  assign out_data = {out_mapped, out_count, out_index};

  // status towards the sequencer
  assign status.action     = action_q;
  assign status.pad_ok     = (32'(item_q.pad) < PADS);
  assign status.slot_ok    = (32'(item_q.slot) < KEYS_PER_BUTTON);
  assign status.b_lt12     = (item_q.button < NRAW4);
  assign status.nb_lt12    = (item_q.new_button < NRAW4);
  assign status.match      = (bm_q == item_q.new_button);
  assign status.jq_last    = (rd_idx == RAW_LAST);
  assign status.sweep_last = (sw_row == ROW_LAST) && (sw_s == S_LAST);
  assign status.scan_last  = (idx_b == BTN_LAST) && (scan_s == S_LAST);
  assign status.idx_last   = (idx_b == BTN_LAST);
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/gamepad_hold_counter_with_key_map_unit.sv =====
// Top level of the gamepad hold counter with keyboard key map.
// Instantiates gphc_ctrl and gphc_dp; depends on gphc_pkg.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready; s_tuser carries the action (key
//   event, pad frame, set key slot, swap button, read button map) and s_tdata
//   the item fields. Results leave on m_tvalid/m_tready with m_tlast on the
//   final beat caused by an item. The override enable is written through
//   cfg_valid/cfg_data; cfg_ready is always high.
// Timing:
//   One item is worked on at a time; s_tready is high only while idle.
//   Swap is a linear search of the 12 map entries. A pad frame first scans
//   the keys, reading one key slot per cycle through the key-map and
//   pressed-key stores, then reads and updates each of the 16 counters in
//   turn on the single counter store port.
// Reset:
//   rst (synchronous) clears the pressed keys at once, then a sweep writes the
//   default key map, the identity button maps and zero counters; no beat is
//   taken then.
// Back-pressure:
//   A stalled m_tready holds the result in the output register and the
//   sequencer waits before loading the next counter result.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_hold_counter_with_key_map_unit #(
  parameter int PADS            = 4,
  parameter int KEYS_PER_BUTTON = 4,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // from bit 0: pad[2], button[4], slot[2], key_code[8], key_down[1],
  // raw_buttons[12], axis_x[11], axis_y[11], new_button[4], zero[1]
  input  logic [gphc_pkg::IN_DATA_W-1:0]   s_tdata,
  // action[3]
  input  logic [2:0]                       s_tuser,
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // from bit 0: button_index[4], hold_count[32], mapped_button[4]
  output logic [gphc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast,
  // override enable register
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);
  import gphc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   item;

  // drop the padding bit; the remaining fields map straight onto the item
  assign item      = s_tdata[$bits(in_item_t)-1:0];
  assign cfg_ready = 1'b1;

  gphc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gphc_dp #(
    .PADS            (PADS),
    .KEYS_PER_BUTTON (KEYS_PER_BUTTON),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .action    (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire
